[rtl/dtfp_pkg.sv]
// Shared types, constants and register codes of the decimal text to fixed-point converter.
`timescale 1ns / 1ps

package dtfp_pkg;

    // Default sizing of the text and of the fraction.
    localparam int MAX_CHARS_DEF    = 256;
    localparam int MAX_DECIMALS_DEF = 18;

    // Width of the unsigned magnitude and of the pending decimal exponent.
    localparam int ACC_W = 63;
    localparam int EX_W  = 5;

    // Glyph codes that the parser recognises on its own.
    localparam logic [15:0] GLYPH_MINUS = 16'd45;
    localparam logic [15:0] GLYPH_ZERO  = 16'd48;
    localparam logic [15:0] GLYPH_NINE  = 16'd57;

    // Largest magnitude, and the largest value that may still be multiplied by ten.
    localparam logic [ACC_W-1:0] VMAX        = {ACC_W{1'b1}};
    localparam logic [ACC_W-1:0] SCALE_LIMIT = 63'd922337203685477580;

    // Register reset values.
    localparam logic [15:0] PERIOD_CHAR_RST   = 16'd46;
    localparam logic [4:0]  DECIMAL_COUNT_RST = 5'd0;
    localparam logic [63:0] RANGE_MIN_RST     = 64'h8000_0000_0000_0000;
    localparam logic [63:0] RANGE_MAX_RST     = 64'h7FFF_FFFF_FFFF_FFFF;

    // Register indexes on the configuration port.
    typedef enum logic [1:0] {
        REG_PERIOD_CHAR   = 2'd0,
        REG_DECIMAL_COUNT = 2'd1,
        REG_RANGE_MIN     = 2'd2,
        REG_RANGE_MAX     = 2'd3
    } reg_index_t;

    // Configuration registers as seen by the datapath.
    typedef struct packed {
        logic [15:0] period_char;
        logic [4:0]  decimal_count;
        logic [63:0] range_min;
        logic [63:0] range_max;
    } cfg_t;

    // One finished text travelling through the scaling pipeline.
    typedef struct packed {
        logic [ACC_W-1:0] mag;
        logic [EX_W-1:0]  ex;
        logic             neg;
        logic             modified;
        logic             is_empty;
    } token_t;

endpackage

[rtl/dtfp_parse.sv]
// Character parser: running accumulator, period window and launch of the finished text.
`timescale 1ns / 1ps

module dtfp_parse #(
    parameter int MAX_CHARS    = dtfp_pkg::MAX_CHARS_DEF,
    parameter int MAX_DECIMALS = dtfp_pkg::MAX_DECIMALS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  dtfp_pkg::cfg_t   cfg,
    input  logic             glyph_valid,
    output logic             glyph_stall,
    input  logic [15:0]      glyph,
    input  logic             last_char,
    input  logic             empty_text,
    output logic             tok_valid,
    input  logic             tok_ready,
    output dtfp_pkg::token_t tok
);

    localparam int CIDX_W = $clog2(MAX_CHARS + 1);
    localparam int WEND_W = $clog2(MAX_CHARS + MAX_DECIMALS + 1);
    localparam int PIDX_W = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
    localparam int ACC_W  = dtfp_pkg::ACC_W;
    localparam int EX_W   = dtfp_pkg::EX_W;

    logic [ACC_W-1:0]  acc_reg,          acc_upd;
    logic [CIDX_W-1:0] char_index_reg,   ci_upd;
    logic [PIDX_W-1:0] period_pos_reg,   pp_upd;
    logic [WEND_W-1:0] window_end_reg,   wend_upd;
    logic              window_set_reg,   wset_upd;
    logic              leading_minus_reg, lm_upd;
    logic              stopped_reg,      stop_upd;
    logic              modified_reg,     mod_upd;
    logic              tok_valid_reg;
    dtfp_pkg::token_t  tok_reg, tok_next;

    logic [EX_W-1:0]    dec_eff;
    logic [ACC_W+3:0]   acc10;
    logic [WEND_W-1:0]  end_pos;
    logic [WEND_W-1:0]  ndec;
    logic               truncated;
    logic               in_ready;
    logic               accept;

    assign in_ready    = !tok_valid_reg || tok_ready;
    assign accept      = glyph_valid && in_ready;
    assign glyph_stall = !in_ready;
    assign tok_valid   = tok_valid_reg;
    assign tok         = tok_reg;

    always_comb
    begin
        dec_eff = (cfg.decimal_count > EX_W'(MAX_DECIMALS)) ? EX_W'(MAX_DECIMALS)
                                                            : cfg.decimal_count;
        acc10 = ({4'd0, acc_reg} << 3) + ({4'd0, acc_reg} << 1) + {{ACC_W{1'b0}}, glyph[3:0]};

        acc_upd  = acc_reg;
        ci_upd   = char_index_reg;
        pp_upd   = period_pos_reg;
        wend_upd = window_end_reg;
        wset_upd = window_set_reg;
        lm_upd   = leading_minus_reg;
        stop_upd = stopped_reg;
        mod_upd  = modified_reg;

        // Characters past the length limit leave the state untouched.
        if (char_index_reg < CIDX_W'(MAX_CHARS))
        begin
            ci_upd = char_index_reg + CIDX_W'(1);
            if (char_index_reg == '0)
            begin
                lm_upd = (glyph == dtfp_pkg::GLYPH_MINUS);
            end
            if (!stopped_reg && !(window_set_reg && (WEND_W'(char_index_reg) >= window_end_reg))
                && (glyph != dtfp_pkg::GLYPH_MINUS))
            begin
                if (glyph == cfg.period_char)
                begin
                    if (!window_set_reg)
                    begin
                        wset_upd = 1'b1;
                        wend_upd = WEND_W'(char_index_reg) + WEND_W'(dec_eff) + WEND_W'(1);
                    end
                    pp_upd = char_index_reg[PIDX_W-1:0];
                end
                else if (glyph inside {[dtfp_pkg::GLYPH_ZERO:dtfp_pkg::GLYPH_NINE]})
                begin
                    if (acc10 <= {4'd0, dtfp_pkg::VMAX})
                    begin
                        acc_upd = acc10[ACC_W-1:0];
                    end
                    else
                    begin
                        acc_upd  = dtfp_pkg::VMAX;
                        mod_upd  = 1'b1;
                        stop_upd = 1'b1;
                    end
                end
            end
        end

        // Decimals actually present, and whether any were dropped.
        truncated = wset_upd && (WEND_W'(ci_upd) > wend_upd);
        end_pos   = (WEND_W'(ci_upd) < wend_upd) ? WEND_W'(ci_upd) : wend_upd;
        ndec      = end_pos - WEND_W'(pp_upd) - WEND_W'(1);

        if (empty_text)
        begin
            tok_next.mag      = '0;
            tok_next.ex       = '0;
            tok_next.neg      = 1'b0;
            tok_next.modified = 1'b0;
            tok_next.is_empty = 1'b1;
        end
        else
        begin
            tok_next.mag      = acc_upd;
            tok_next.ex       = wset_upd ? (dec_eff - EX_W'(ndec)) : dec_eff;
            tok_next.neg      = lm_upd;
            tok_next.modified = mod_upd || truncated;
            tok_next.is_empty = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg           <= '0;
            char_index_reg    <= '0;
            period_pos_reg    <= '0;
            window_end_reg    <= '1;
            window_set_reg    <= 1'b0;
            leading_minus_reg <= 1'b0;
            stopped_reg       <= 1'b0;
            modified_reg      <= 1'b0;
            tok_valid_reg     <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                if (last_char)
                begin
                    acc_reg           <= '0;
                    char_index_reg    <= '0;
                    period_pos_reg    <= '0;
                    window_end_reg    <= '1;
                    window_set_reg    <= 1'b0;
                    leading_minus_reg <= 1'b0;
                    stopped_reg       <= 1'b0;
                    modified_reg      <= 1'b0;
                end
                else
                begin
                    acc_reg           <= acc_upd;
                    char_index_reg    <= ci_upd;
                    period_pos_reg    <= pp_upd;
                    window_end_reg    <= wend_upd;
                    window_set_reg    <= wset_upd;
                    leading_minus_reg <= lm_upd;
                    stopped_reg       <= stop_upd;
                    modified_reg      <= mod_upd;
                end
            end
            if (in_ready)
            begin
                tok_valid_reg <= accept && last_char;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && last_char)
        begin
            tok_reg <= tok_next;
        end
    end

endmodule

[rtl/dtfp_scale.sv]
// One stage of the decimal scaling pipeline: multiplies by ten once while decimals are missing, or saturates.
`timescale 1ns / 1ps

module dtfp_scale (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  dtfp_pkg::token_t in_tok,
    output logic             out_valid,
    input  logic             out_ready,
    output dtfp_pkg::token_t out_tok
);

    localparam int ACC_W = dtfp_pkg::ACC_W;
    localparam int EX_W  = dtfp_pkg::EX_W;

    logic             valid_reg;
    dtfp_pkg::token_t tok_reg, tok_next;
    logic [ACC_W-1:0] mag10;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_tok   = tok_reg;

    always_comb
    begin
        mag10    = {in_tok.mag[ACC_W-4:0], 3'b000} + {in_tok.mag[ACC_W-2:0], 1'b0};
        tok_next = in_tok;
        if (in_tok.ex != '0)
        begin
            if (in_tok.mag > dtfp_pkg::SCALE_LIMIT)
            begin
                // Saturated: no further scaling is needed.
                tok_next.mag      = dtfp_pkg::VMAX;
                tok_next.modified = 1'b1;
                tok_next.ex       = '0;
            end
            else
            begin
                tok_next.mag = mag10;
                tok_next.ex  = in_tok.ex - EX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            tok_reg <= tok_next;
        end
    end

endmodule

[rtl/dtfp_clamp.sv]
// Sign, range clamp and result register of the converter.
`timescale 1ns / 1ps

module dtfp_clamp (
    input  logic               clk,
    input  logic               rst_n,
    input  dtfp_pkg::cfg_t     cfg,
    input  logic               tok_valid,
    output logic               tok_ready,
    input  dtfp_pkg::token_t   tok,
    output logic               result_valid,
    input  logic               result_stall,
    output logic signed [63:0] scaled_value,
    output logic               was_modified
);

    logic               result_valid_reg;
    logic signed [63:0] scaled_value_reg, value_next;
    logic               was_modified_reg, modified_next;
    logic signed [63:0] lo, hi, pos, negated;

    assign tok_ready    = !result_valid_reg || !result_stall;
    assign result_valid = result_valid_reg;
    assign scaled_value = scaled_value_reg;
    assign was_modified = was_modified_reg;

    always_comb
    begin
        lo      = $signed(cfg.range_min);
        hi      = $signed(cfg.range_max);
        pos     = $signed({1'b0, tok.mag});
        negated = -pos;
        modified_next = tok.modified;
        if (tok.is_empty)
        begin
            value_next    = '0;
            modified_next = 1'b0;
        end
        else if (tok.neg)
        begin
            if ((tok.mag == dtfp_pkg::VMAX) || (negated < lo))
            begin
                value_next = lo;
            end
            else
            begin
                value_next = negated;
            end
        end
        else
        begin
            value_next = (pos > hi) ? hi : pos;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (tok_ready)
        begin
            result_valid_reg <= tok_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok_ready && tok_valid)
        begin
            scaled_value_reg <= value_next;
            was_modified_reg <= modified_next;
        end
    end

endmodule

[rtl/decimal_text_to_fixed_point_top.sv]
// Top level of the decimal text to fixed-point converter.
//
// The glyph channel takes one character of a text per beat (glyph, last_char,
// empty_text); a beat is taken at a rising edge with glyph_valid high and
// glyph_stall low. A beat with last_char high closes the text and produces one
// result beat on the result channel (scaled_value, was_modified), taken when
// result_valid is high and result_stall is low. Other beats produce nothing.
// A closing beat with empty_text high gives a zero result with no clamping.
// One glyph is accepted every cycle while glyph_stall is low. A result is offered
// once its closing beat has passed through the parser's launch register, which
// the closing beat itself loads, then through each stage of the multiply-by-ten
// pipeline that fills in missing decimals, and then through the clamp and result
// register.
// When the receiver stalls, the pipeline keeps filling its empty stages and
// glyph_stall rises only once a finished text can no longer leave the parser.
// Registers are written on the configuration channel (cfg_valid with cfg_ready,
// always high); the user must write them only while the block is idle, as the
// block does not enforce it. Reset clears the parse state, empties the pipeline and loads the register defaults.
`timescale 1ns / 1ps

module decimal_text_to_fixed_point_top #(
    parameter int MAX_CHARS    = dtfp_pkg::MAX_CHARS_DEF,
    parameter int MAX_DECIMALS = dtfp_pkg::MAX_DECIMALS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               glyph_valid,
    output logic               glyph_stall,
    input  logic [15:0]        glyph,
    input  logic               last_char,
    input  logic               empty_text,
    output logic               result_valid,
    input  logic               result_stall,
    output logic signed [63:0] scaled_value,
    output logic               was_modified,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [63:0]        cfg_data
);

    // Configuration registers.
    dtfp_pkg::cfg_t cfg_reg;

    // Finished texts travel through the scaling stages as tokens; index 0 is
    // the parser's launch register and the last index feeds the clamp.
    dtfp_pkg::token_t tok       [0:MAX_DECIMALS];
    logic             tok_valid [0:MAX_DECIMALS];
    logic             tok_ready [0:MAX_DECIMALS];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.period_char   <= dtfp_pkg::PERIOD_CHAR_RST;
            cfg_reg.decimal_count <= dtfp_pkg::DECIMAL_COUNT_RST;
            cfg_reg.range_min     <= dtfp_pkg::RANGE_MIN_RST;
            cfg_reg.range_max     <= dtfp_pkg::RANGE_MAX_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                dtfp_pkg::REG_PERIOD_CHAR:   cfg_reg.period_char   <= cfg_data[15:0];
                dtfp_pkg::REG_DECIMAL_COUNT: cfg_reg.decimal_count <= cfg_data[4:0];
                dtfp_pkg::REG_RANGE_MIN:     cfg_reg.range_min     <= cfg_data;
                dtfp_pkg::REG_RANGE_MAX:     cfg_reg.range_max     <= cfg_data;
                default:                     cfg_reg               <= cfg_reg;
            endcase
        end
    end

    dtfp_parse #(
        .MAX_CHARS    (MAX_CHARS),
        .MAX_DECIMALS (MAX_DECIMALS)
    ) u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .glyph_valid (glyph_valid),
        .glyph_stall (glyph_stall),
        .glyph       (glyph),
        .last_char   (last_char),
        .empty_text  (empty_text),
        .tok_valid   (tok_valid[0]),
        .tok_ready   (tok_ready[0]),
        .tok         (tok[0])
    );

    // One multiply-by-ten stage for each decimal that may be missing.
    for (genvar i = 0; i < MAX_DECIMALS; i++)
    begin : g_scale
        dtfp_scale u_scale (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (tok_valid[i]),
            .in_ready  (tok_ready[i]),
            .in_tok    (tok[i]),
            .out_valid (tok_valid[i+1]),
            .out_ready (tok_ready[i+1]),
            .out_tok   (tok[i+1])
        );
    end

    dtfp_clamp u_clamp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .tok_valid    (tok_valid[MAX_DECIMALS]),
        .tok_ready    (tok_ready[MAX_DECIMALS]),
        .tok          (tok[MAX_DECIMALS]),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .scaled_value (scaled_value),
        .was_modified (was_modified)
    );

`ifndef SYNTH
    // With no result waiting, every stage can move, so the parser never stalls.
    a_no_stall_when_drained : assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> !glyph_stall)
        else $error("glyph channel stalled with an empty result register");

    // A new result only ever comes out of the last pipeline stage.
    a_result_from_pipe : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(tok_valid[MAX_DECIMALS]))
        else $error("result appeared without a token at the clamp");

    // By the clamp, all missing decimals have been filled in.
    a_scaling_done : assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid[MAX_DECIMALS] |-> (tok[MAX_DECIMALS].ex == '0))
        else $error("token reached the clamp with decimals still to scale");
`endif

endmodule
